### hdl/tcpm_pkg.sv
// Shared types and constants for the touch calibrated position mapper.
package tcpm_pkg;

	// Field widths
	localparam int RawW     = 12;
	localparam int CfgW     = 12;
	localparam int NumCfg   = 8;
	localparam int CfgIdxW  = 4;
	localparam int CfgSelW  = $clog2(NumCfg);
	localparam int CoefScale = 1024;
	localparam int ScaleSh  = $clog2(CoefScale);
	localparam int FullW    = 23;
	localparam int ProdW    = 34;
	localparam int GainW    = 20;
	localparam int OffW     = 32;
	localparam int MapW     = 32;
	localparam int PosW     = 16;

	// Calibration register indexes
	localparam logic [CfgSelW-1:0] RegLtX = CfgSelW'(0);
	localparam logic [CfgSelW-1:0] RegLtY = CfgSelW'(1);
	localparam logic [CfgSelW-1:0] RegRtX = CfgSelW'(2);
	localparam logic [CfgSelW-1:0] RegRtY = CfgSelW'(3);
	localparam logic [CfgSelW-1:0] RegLbX = CfgSelW'(4);
	localparam logic [CfgSelW-1:0] RegLbY = CfgSelW'(5);
	localparam logic [CfgSelW-1:0] RegRbX = CfgSelW'(6);
	localparam logic [CfgSelW-1:0] RegRbY = CfgSelW'(7);

	// Axis codes
	localparam logic AxisX = 1'b0;
	localparam logic AxisY = 1'b1;

	typedef logic [CfgW-1:0] cfg_word_t;

	localparam cfg_word_t CfgReset [NumCfg] = '{
		12'd280, 12'd1790, 12'd1733, 12'd1761, 12'd344, 12'd213, 12'd1771, 12'd256
	};

	// Edge midpoints of the reset calibration
	localparam cfg_word_t ResetXLo =
		cfg_word_t'((int'(CfgReset[RegLtX]) + int'(CfgReset[RegLbX])) / 2);
	localparam cfg_word_t ResetXHi =
		cfg_word_t'((int'(CfgReset[RegRtX]) + int'(CfgReset[RegRbX])) / 2);
	localparam cfg_word_t ResetYLo =
		cfg_word_t'((int'(CfgReset[RegLtY]) + int'(CfgReset[RegRtY])) / 2);
	localparam cfg_word_t ResetYHi =
		cfg_word_t'((int'(CfgReset[RegLbY]) + int'(CfgReset[RegRbY])) / 2);
	localparam logic ResetSpanErr = (ResetXLo == ResetXHi) || (ResetYLo == ResetYHi);
	localparam logic [1:0] ResetDirty = {ResetYLo != ResetYHi, ResetXLo != ResetXHi};

	// Controller to datapath
	typedef struct packed {
		logic load_axis;
		logic axis;
		logic div_start;
		logic div_sel_off;
		logic commit_gain;
		logic commit_off;
		logic store_first;
		logic take_second;
		logic map_mul;
		logic load_out;
	} tcpm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] dirty;
		logic       div_done;
		logic       pending;
		logic       out_free;
	} tcpm_status_t;

endpackage

### hdl/touch_calibrated_position_mapper.sv
// Top level of the touch calibrated position mapper.
//
// Raw touch samples (raw_x, raw_y, touch_now) enter on the in_valid/in_ready
// channel; results leave on out_valid/out_ready. Two samples form one poll:
// a released sample with nothing pending, or any sample after a pending one,
// ends the poll and yields one result beat. A pressed first sample is stored
// and yields none. Mapped positions are valid when touched is high.
// Eight calibration registers are written through cfg_we/cfg_index/cfg_data
// (indexes above 7 are ignored). Each write re-derives gain and offset of
// every axis whose new edge span is nonzero, one axis after the other, on
// one shared bit-serial divider, during which in_ready stays low. The same
// derivation runs for both axes right after reset, before any sample is taken.
// A sample that stores only fills the first-sample register; a poll-ending
// one is averaged, multiplied and scaled into the output register, and the
// input reopens as its result shows. While the receiver stalls, a first
// sample may still be taken, and a poll-ending one waits in the last stage
// until the output register frees.
module touch_calibrated_position_mapper import tcpm_pkg::*; #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 320,
	parameter int RAW_BITS      = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [CfgW-1:0]        cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [RawW-1:0]        raw_x,
	input  logic [RawW-1:0]        raw_y,
	input  logic                   touch_now,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [PosW-1:0] pos_x,
	output logic signed [PosW-1:0] pos_y,
	output logic                   touched,
	output logic                   calib_bad
);

	tcpm_cmd_t    cmd;
	tcpm_status_t stat;

	tcpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.touch_now (touch_now),
		.cfg_we    (cfg_we),
		.stat      (stat),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	tcpm_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.RAW_BITS      (RAW_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.raw_x     (raw_x),
		.raw_y     (raw_y),
		.touch_now (touch_now),
		.cmd       (cmd),
		.stat      (stat),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.touched   (touched),
		.calib_bad (calib_bad),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

### hdl/tcpm_divider.sv
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
module tcpm_divider import tcpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ProdW-1:0] dividend,
	input  logic [CfgW-1:0]  divisor,
	output logic [ProdW-1:0] quotient,
	output logic             done
);

	localparam int CntW = $clog2(ProdW + 1);

	logic            run_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [CfgW-1:0] rem_q;
	logic [CfgW-1:0] dsr_q;
	logic [ProdW-1:0] quo_q;

	logic [CfgW:0] shifted;
	logic [CfgW:0] diff;
	logic          ge;

	// Trial subtract of the next dividend bit
	always_comb begin
		shifted = {rem_q, quo_q[ProdW-1]};
		diff    = shifted - {1'b0, dsr_q};
		ge      = shifted >= {1'b0, dsr_q};
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CntW'(ProdW);
		end else if (run_q) begin
			cnt_q  <= cnt_q - CntW'(1);
			done_q <= (cnt_q == CntW'(1));
			if (cnt_q == CntW'(1)) begin
				run_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[CfgW-1:0] : shifted[CfgW-1:0];
			quo_q <= {quo_q[ProdW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### hdl/tcpm_datapath.sv
// Datapath: calibration registers, coefficient derivation, sample pairing and mapping.
module tcpm_datapath import tcpm_pkg::*; #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 320,
	parameter int RAW_BITS      = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [CfgW-1:0]        cfg_data,
	input  logic [RawW-1:0]        raw_x,
	input  logic [RawW-1:0]        raw_y,
	input  logic                   touch_now,
	input  tcpm_cmd_t              cmd,
	output tcpm_status_t           stat,
	output logic signed [PosW-1:0] pos_x,
	output logic signed [PosW-1:0] pos_y,
	output logic                   touched,
	output logic                   calib_bad,
	output logic                   out_valid,
	input  logic                   out_ready
);

	localparam int MaskBits = (RAW_BITS < RawW) ? RAW_BITS : RawW;
	localparam logic [RawW-1:0] RawMask = RawW'((64'd1 << MaskBits) - 64'd1);
	localparam logic [FullW-1:0] FullX = FullW'(SCREEN_WIDTH * CoefScale);
	localparam logic [FullW-1:0] FullY = FullW'(SCREEN_HEIGHT * CoefScale);
	localparam logic [ProdW-1:0] GainLim = ProdW'(1) << (GainW - 1);
	localparam logic [ProdW-1:0] OffLim  = ProdW'(1) << (OffW - 1);
	localparam logic signed [GainW-1:0] GainMax = {1'b0, {(GainW-1){1'b1}}};
	localparam logic signed [GainW-1:0] GainMin = {1'b1, {(GainW-1){1'b0}}};
	localparam logic signed [OffW-1:0]  OffMax  = {1'b0, {(OffW-1){1'b1}}};
	localparam logic signed [OffW-1:0]  OffMin  = {1'b1, {(OffW-1){1'b0}}};
	localparam logic signed [MapW-ScaleSh:0] PosMax = (MapW-ScaleSh+1)'(32767);
	localparam logic signed [MapW-ScaleSh:0] PosMin = -(MapW-ScaleSh+1)'(32768);

	function automatic cfg_word_t mid(cfg_word_t a, cfg_word_t b);
		logic [CfgW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CfgW:1];
	endfunction

	// (gain*avg + offset)/1024 toward zero, saturated to 16 bits
	function automatic logic signed [PosW-1:0] map_finish(logic signed [MapW-1:0] p,
			logic signed [OffW-1:0] o);
		logic signed [MapW:0]         s;
		logic signed [MapW:0]         a;
		logic signed [MapW-ScaleSh:0] qv;
		s  = {p[MapW-1], p} + {o[OffW-1], o};
		a  = s[MapW] ? s + (MapW+1)'(CoefScale - 1) : s;
		qv = a[MapW:ScaleSh];
		if (qv > PosMax) begin
			return PosMax[PosW-1:0];
		end else if (qv < PosMin) begin
			return PosMin[PosW-1:0];
		end
		return qv[PosW-1:0];
	endfunction

	cfg_word_t cfg_q [NumCfg];
	cfg_word_t cfg_nx [NumCfg];
	logic      cfg_hit;
	cfg_word_t x_lo_nx, x_hi_nx, y_lo_nx, y_hi_nx;

	cfg_word_t x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic [1:0] dirty_q;
	logic [1:0] dirty_nx;
	logic       span_err_q;

	logic                    span_neg_q;
	cfg_word_t               span_mag_q;
	logic [FullW-1:0]        full_q;
	logic [ProdW-1:0]        lo_prod_q;
	cfg_word_t               lo_sel, hi_sel;
	logic [FullW-1:0]        full_sel;
	logic [CfgW:0]           span;
	logic [CfgW:0]           span_abs;

	logic [ProdW-1:0]        div_dividend;
	logic [ProdW-1:0]        quo;
	logic [ProdW-1:0]        quo_neg;
	logic                    div_done;
	logic signed [GainW-1:0] gain_nx;
	logic signed [OffW-1:0]  off_nx;

	logic signed [GainW-1:0] x_gain_q, y_gain_q;
	logic signed [OffW-1:0]  x_off_q, y_off_q;

	logic                    pending_q;
	logic [RawW-1:0]         first_x_q, first_y_q;
	logic [RawW-1:0]         rx_m, ry_m;
	logic [RawW-1:0]         avg_x_s1, avg_y_s1;
	logic                    touched_s1;
	logic signed [MapW-1:0]  prod_x_s2, prod_y_s2;
	logic                    touched_s2;

	logic signed [PosW-1:0]  pos_x_q, pos_y_q;
	logic                    touched_q, calib_bad_q, out_valid_q;

	// Register file image after this cycle's write, and its edge midpoints
	always_comb begin
		cfg_hit = cfg_we && (cfg_index < CfgIdxW'(NumCfg));
		cfg_nx  = cfg_q;
		if (cfg_hit) begin
			cfg_nx[cfg_index[CfgSelW-1:0]] = cfg_data;
		end
		x_lo_nx = mid(cfg_nx[RegLtX], cfg_nx[RegLbX]);
		x_hi_nx = mid(cfg_nx[RegRtX], cfg_nx[RegRbX]);
		y_lo_nx = mid(cfg_nx[RegLtY], cfg_nx[RegRtY]);
		y_hi_nx = mid(cfg_nx[RegLbY], cfg_nx[RegRbY]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgReset;
		end else if (cfg_hit) begin
			cfg_q <= cfg_nx;
		end
	end

	// Dirty flags: a new nonzero span outranks the load that clears the axis
	always_comb begin
		dirty_nx = dirty_q;
		if (cmd.load_axis) begin
			dirty_nx[cmd.axis] = 1'b0;
		end
		if (cfg_hit) begin
			if (x_lo_nx != x_hi_nx) begin
				dirty_nx[AxisX] = 1'b1;
			end
			if (y_lo_nx != y_hi_nx) begin
				dirty_nx[AxisY] = 1'b1;
			end
		end
	end

	// Latest nonzero-span edges per axis; an axis is dirty until its derivation loads it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lo_q     <= ResetXLo;
			x_hi_q     <= ResetXHi;
			y_lo_q     <= ResetYLo;
			y_hi_q     <= ResetYHi;
			dirty_q    <= ResetDirty;
			span_err_q <= ResetSpanErr;
		end else begin
			dirty_q <= dirty_nx;
			if (cfg_hit) begin
				if (x_lo_nx != x_hi_nx) begin
					x_lo_q <= x_lo_nx;
					x_hi_q <= x_hi_nx;
				end
				if (y_lo_nx != y_hi_nx) begin
					y_lo_q <= y_lo_nx;
					y_hi_q <= y_hi_nx;
				end
				span_err_q <= (x_lo_nx == x_hi_nx) || (y_lo_nx == y_hi_nx);
			end
		end
	end

	// Axis operand setup: span magnitude, sign and full*lo
	always_comb begin
		lo_sel   = (cmd.axis == AxisY) ? y_lo_q : x_lo_q;
		hi_sel   = (cmd.axis == AxisY) ? y_hi_q : x_hi_q;
		full_sel = (cmd.axis == AxisY) ? FullY : FullX;
		span     = {1'b0, hi_sel} - {1'b0, lo_sel};
		span_abs = span[CfgW] ? (~span + (CfgW+1)'(1)) : span;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_axis) begin
			span_neg_q <= span[CfgW];
			span_mag_q <= span_abs[CfgW-1:0];
			full_q     <= full_sel;
			lo_prod_q  <= {{(ProdW-FullW){1'b0}}, full_sel} * {{(ProdW-CfgW){1'b0}}, lo_sel};
		end
	end

	assign div_dividend = cmd.div_sel_off ? lo_prod_q : {{(ProdW-FullW){1'b0}}, full_q};

	tcpm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (span_mag_q),
		.quotient (quo),
		.done     (div_done)
	);

	// Sign and saturation of the quotient
	always_comb begin
		quo_neg = ~quo + ProdW'(1);
		if (span_neg_q) begin
			gain_nx = (quo > GainLim) ? GainMin : quo_neg[GainW-1:0];
		end else begin
			gain_nx = (quo >= GainLim) ? GainMax : quo[GainW-1:0];
		end
		// offset = -(full*lo)/span: negative when span is positive
		if (!span_neg_q) begin
			off_nx = (quo > OffLim) ? OffMin : quo_neg[OffW-1:0];
		end else begin
			off_nx = (quo >= OffLim) ? OffMax : quo[OffW-1:0];
		end
	end

	// Coefficients
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_gain_q <= '0;
			y_gain_q <= '0;
			x_off_q  <= '0;
			y_off_q  <= '0;
		end else begin
			if (cmd.commit_gain) begin
				if (cmd.axis == AxisY) begin
					y_gain_q <= gain_nx;
				end else begin
					x_gain_q <= gain_nx;
				end
			end
			if (cmd.commit_off) begin
				if (cmd.axis == AxisY) begin
					y_off_q <= off_nx;
				end else begin
					x_off_q <= off_nx;
				end
			end
		end
	end

	// Poll pairing
	assign rx_m = raw_x & RawMask;
	assign ry_m = raw_y & RawMask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			first_x_q <= '0;
			first_y_q <= '0;
		end else if (cmd.store_first) begin
			pending_q <= 1'b1;
			first_x_q <= rx_m;
			first_y_q <= ry_m;
		end else if (cmd.take_second) begin
			pending_q <= 1'b0;
		end
	end

	// Mapping pipeline: average, multiply
	always_ff @(posedge clk) begin
		if (cmd.take_second) begin
			avg_x_s1   <= mid(first_x_q, rx_m);
			avg_y_s1   <= mid(first_y_q, ry_m);
			touched_s1 <= pending_q & touch_now;
		end
		if (cmd.map_mul) begin
			prod_x_s2  <= x_gain_q * $signed({1'b0, avg_x_s1});
			prod_y_s2  <= y_gain_q * $signed({1'b0, avg_y_s1});
			touched_s2 <= touched_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pos_x_q     <= touched_s2 ? map_finish(prod_x_s2, x_off_q) : '0;
			pos_y_q     <= touched_s2 ? map_finish(prod_y_s2, y_off_q) : '0;
			touched_q   <= touched_s2;
			calib_bad_q <= span_err_q;
		end
	end

	assign stat.dirty    = dirty_q;
	assign stat.div_done = div_done;
	assign stat.pending  = pending_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign touched   = touched_q;
	assign calib_bad = calib_bad_q;
	assign out_valid = out_valid_q;

endmodule

### hdl/tcpm_ctrl.sv
// Controller: sequences coefficient derivation and the mapping of each poll.
module tcpm_ctrl import tcpm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         touch_now,
	input  logic         cfg_we,
	input  tcpm_status_t stat,
	output logic         in_ready,
	output tcpm_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_GAIN_GO,
		ST_GAIN_WAIT,
		ST_OFF_GO,
		ST_OFF_WAIT,
		ST_MAP_MUL,
		ST_MAP_OUT
	} state_t;

	state_t state_q;
	logic   axis_q;
	logic   rdy;
	logic   fire;

	// Commands decoded from state
	always_comb begin
		rdy      = (state_q == ST_IDLE) && (stat.dirty == 2'b00) && !cfg_we;
		fire     = in_valid && rdy;
		cmd      = '0;
		cmd.axis = axis_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.store_first = fire && !stat.pending && touch_now;
				cmd.take_second = fire && (stat.pending || !touch_now);
			end
			ST_LOAD: begin
				cmd.load_axis = 1'b1;
			end
			ST_GAIN_GO: begin
				cmd.div_start = 1'b1;
			end
			ST_GAIN_WAIT: begin
				cmd.commit_gain = stat.div_done;
			end
			ST_OFF_GO: begin
				cmd.div_start   = 1'b1;
				cmd.div_sel_off = 1'b1;
			end
			ST_OFF_WAIT: begin
				cmd.div_sel_off = 1'b1;
				cmd.commit_off  = stat.div_done;
			end
			ST_MAP_MUL: begin
				cmd.map_mul = 1'b1;
			end
			ST_MAP_OUT: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	// State and axis under derivation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AxisX;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					priority if (stat.dirty[AxisX]) begin
						axis_q  <= AxisX;
						state_q <= ST_LOAD;
					end else if (stat.dirty[AxisY]) begin
						axis_q  <= AxisY;
						state_q <= ST_LOAD;
					end else if (cmd.take_second) begin
						state_q <= ST_MAP_MUL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOAD:      state_q <= ST_GAIN_GO;
				ST_GAIN_GO:   state_q <= ST_GAIN_WAIT;
				ST_GAIN_WAIT: begin
					if (stat.div_done) begin
						state_q <= ST_OFF_GO;
					end
				end
				ST_OFF_GO:    state_q <= ST_OFF_WAIT;
				ST_OFF_WAIT: begin
					if (stat.div_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MAP_MUL:   state_q <= ST_MAP_OUT;
				ST_MAP_OUT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = rdy;

endmodule
